FILE: rtl/core/bglfb_pkg.sv
`default_nettype none
package bglfb_pkg;

  // command codes
  typedef enum logic [2:0] {
    OP_HEIGHT = 3'd0,
    OP_RANGE  = 3'd1,
    OP_DOT    = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_PIXEL  = 3'd4,
    OP_SHOW   = 3'd5
  } op_t;

  // geometry of the bar graph
  localparam int unsigned ROW_COUNT    = 20;
  localparam int unsigned WORD_WIDTH   = 16;
  localparam int unsigned NIBBLE_SHIFT = 4;
  localparam logic [3:0]  BAR_COUNT    = 4'd10;
  localparam logic [3:0]  BAR_SPLIT    = 4'd6;   // bars from here use the upper nibble
  localparam logic [3:0]  HI_WORD_BASE = 4'd10;  // 8+2: first word of the top-row group
  localparam logic [3:0]  HI_WORD_WRAP = 4'd4;   // base for bars 6..9 (10 - 6)
  localparam logic [7:0]  MAX_ROW      = 8'd19;
  localparam logic [7:0]  HEIGHT_MAX   = 8'd20;
  localparam logic [7:0]  HEIGHT_LIMIT = 8'd127;

  // controller -> datapath
  typedef struct packed {
    logic capture;  // latch a new transaction
    logic rd_lo;    // read the lower-row word of the bar
    logic wr_lo;    // write lower-row word, read top-row word
    logic wr_hi;    // write top-row word
    logic show;     // read one word of the show run
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic op_show;   // incoming transaction is a show
    logic op_draw;   // incoming transaction changes the buffer
    logic show_end;  // show counter at the last word
  } stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/bglfb_dpath.sv
`default_nettype none
module bglfb_dpath #(
  parameter int unsigned WORD_COUNT = 16,
  localparam int unsigned IDX_W = $clog2(WORD_COUNT)
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire bglfb_pkg::cmd_t                       cmd,
  output bglfb_pkg::stat_t                           stat,
  input  wire logic [2:0]                            opcode,
  input  wire logic [3:0]                            column,
  input  wire logic [7:0]                            level,
  input  wire logic [7:0]                            bottom,
  input  wire logic                                  pixel_value,
  output logic                                       strobe,
  output logic [IDX_W-1:0]                           word_index,
  output logic [bglfb_pkg::WORD_WIDTH-1:0]           word_value,
  output logic                                       last
);

  localparam int unsigned RC = bglfb_pkg::ROW_COUNT;
  localparam int unsigned WW = bglfb_pkg::WORD_WIDTH;

  // frame buffer with per-word valid bits (invalid reads as zero)
  logic [WW-1:0]         mem [WORD_COUNT];
  logic [WORD_COUNT-1:0] vld;
  logic [WW-1:0]         rdata;

  // captured transaction; masks are indexed by row counted from the bottom
  logic [3:0]    bar_q;
  logic [RC-1:0] aff_q;
  logic [RC-1:0] on_q;
  logic [IDX_W-1:0] cnt;

  logic [RC-1:0] aff_d;
  logic [RC-1:0] on_d;
  logic [4:0]    h;
  logic [4:0]    top5;
  logic [4:0]    bot5;
  logic [4:0]    top_plus;
  logic [RC:0]   upto;
  logic [RC-1:0] lowm;

  logic [IDX_W-1:0] lo_addr;
  logic [IDX_W-1:0] hi_addr;
  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic             re;
  logic             we;
  logic [WW-1:0]    wdata;
  logic [WW-1:0]    hi_aff;
  logic [WW-1:0]    hi_on;

  // decode of the incoming transaction
  always_comb begin
    stat.op_show  = (opcode == bglfb_pkg::OP_SHOW);
    stat.op_draw  = (opcode <= bglfb_pkg::OP_PIXEL) && (column < bglfb_pkg::BAR_COUNT);
    stat.show_end = (cnt == IDX_W'(WORD_COUNT - 1));
  end

  // clamped operands
  always_comb begin
    if (level > bglfb_pkg::HEIGHT_LIMIT) begin
      h = 5'd0;
    end else if (level > bglfb_pkg::HEIGHT_MAX) begin
      h = bglfb_pkg::HEIGHT_MAX[4:0];
    end else begin
      h = level[4:0];
    end
    top5 = (level > bglfb_pkg::MAX_ROW) ? bglfb_pkg::MAX_ROW[4:0] : level[4:0];
    bot5 = (bottom > bglfb_pkg::MAX_ROW) ? bglfb_pkg::MAX_ROW[4:0] : bottom[4:0];
    if (bot5 > top5) begin
      bot5 = top5;
    end
    top_plus = top5 + 5'd1;
    upto     = (RC+1)'(1) << top_plus;
    upto     = upto - (RC+1)'(1);
    lowm     = (RC'(1) << bot5) - RC'(1);
  end

  // lit and touched rows for each command
  always_comb begin
    aff_d = '0;
    on_d  = '0;
    unique case (bglfb_pkg::op_t'(opcode))
      bglfb_pkg::OP_HEIGHT: begin
        aff_d = '1;
        on_d  = RC'((RC+1)'((RC+1)'(1) << h) - (RC+1)'(1));
      end
      bglfb_pkg::OP_RANGE: begin
        aff_d = '1;
        on_d  = upto[RC-1:0] & ~lowm;
      end
      bglfb_pkg::OP_DOT: begin
        aff_d = RC'(1) << top5;
        on_d  = aff_d;
      end
      bglfb_pkg::OP_CLEAR: begin
        aff_d = '1;
      end
      bglfb_pkg::OP_PIXEL: begin
        if (level <= bglfb_pkg::MAX_ROW) begin
          aff_d = RC'(1) << (bglfb_pkg::MAX_ROW[4:0] - level[4:0]);
          on_d  = pixel_value ? aff_d : '0;
        end
      end
      default: begin
        aff_d = '0;
        on_d  = '0;
      end
    endcase
  end

  // transaction capture and show counter
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      bar_q <= column;
      aff_q <= aff_d;
      on_q  <= on_d;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.capture) begin
      cnt <= '0;
    end else if (cmd.show) begin
      cnt <= cnt + IDX_W'(1);
    end
  end

  // word addresses of the bar: rows 4..19 (from the top) in word bar, rows 0..3 in a top-row group word
  always_comb begin
    lo_addr = IDX_W'(bar_q);
    if (bar_q < bglfb_pkg::BAR_SPLIT) begin
      hi_addr = IDX_W'(bar_q + bglfb_pkg::HI_WORD_BASE);
      hi_aff  = WW'(aff_q[RC-1:WW]);
      hi_on   = WW'(on_q[RC-1:WW]);
    end else begin
      hi_addr = IDX_W'(bar_q + bglfb_pkg::HI_WORD_WRAP);
      hi_aff  = WW'(aff_q[RC-1:WW]) << bglfb_pkg::NIBBLE_SHIFT;
      hi_on   = WW'(on_q[RC-1:WW]) << bglfb_pkg::NIBBLE_SHIFT;
    end
  end

  // memory port selection and read-modify-write merge
  always_comb begin
    re    = cmd.rd_lo | cmd.wr_lo | cmd.show;
    raddr = cmd.rd_lo ? lo_addr : (cmd.wr_lo ? hi_addr : cnt);
    we    = cmd.wr_lo | cmd.wr_hi;
    waddr = cmd.wr_lo ? lo_addr : hi_addr;
    if (cmd.wr_lo) begin
      wdata = (rdata & ~aff_q[WW-1:0]) | (on_q[WW-1:0] & aff_q[WW-1:0]);
    end else begin
      wdata = (rdata & ~hi_aff) | (hi_on & hi_aff);
    end
  end

  // frame buffer storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= vld[raddr] ? mem[raddr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we) begin
      vld[waddr] <= 1'b1;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      last   <= 1'b0;
    end else begin
      strobe <= cmd.show;
      last   <= cmd.show & stat.show_end;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.show) begin
      word_index <= cnt;
    end
  end

  assign word_value = rdata;

endmodule
`default_nettype wire

FILE: rtl/core/bglfb_ctrl.sv
`default_nettype none
module bglfb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire bglfb_pkg::stat_t stat,
  output logic                  busy,
  output bglfb_pkg::cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_LO,
    ST_WR_LO,
    ST_WR_HI,
    ST_SHOW
  } state_t;

  state_t state;

  // commands to the datapath
  always_comb begin
    cmd.capture = start & ~busy;
    cmd.rd_lo   = (state == ST_RD_LO);
    cmd.wr_lo   = (state == ST_WR_LO);
    cmd.wr_hi   = (state == ST_WR_HI);
    cmd.show    = (state == ST_SHOW);
  end

  // sequencer: draw is read/write of two words, show walks the buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (start && stat.op_show) begin
            state <= ST_SHOW;
            busy  <= 1'b1;
          end else if (start && stat.op_draw) begin
            state <= ST_RD_LO;
            busy  <= 1'b1;
          end
        end
        ST_RD_LO: begin
          state <= ST_WR_LO;
        end
        ST_WR_LO: begin
          state <= ST_WR_HI;
        end
        ST_WR_HI: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
        ST_SHOW: begin
          if (stat.show_end) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/bar_graph_led_frame_buffer.sv
`default_nettype none
// Frame buffer for a 10-bar, 20-LED bar graph (sixteen 16-bit driver words).
// Command channel: a transaction is taken at a rising edge with start high
// and busy low; opcode selects bar height, bar range, dot, clear bar,
// pixel write or show, with column, level, bottom and pixel_value as
// operands.
// Drawing commands return nothing. Each one does a read-modify-write of the
// bar's two words through the single write port of the buffer: busy is high
// through the read and both writes; no command is taken meanwhile. Commands
// with a bar above 9 or an unused opcode are taken and leave busy low.
// Show: busy is high during the reads, one buffer read per cycle. The first
// word is on the result ports from the edge after the accepting edge, one
// word per cycle, all 16 words, each marked by strobe for one cycle; last is
// high on word 15.
// Results cannot be held off by the receiver. The next command may be
// taken while the final word is on the result ports.
// Reset (rst, synchronous) clears the controller and marks every buffer
// word as zero at once; commands are taken right after reset.
module bar_graph_led_frame_buffer #(
  parameter int unsigned WORD_COUNT = 16,
  localparam int unsigned IDX_W = $clog2(WORD_COUNT)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [2:0]                  opcode,
  input  wire logic [3:0]                  column,
  input  wire logic [7:0]                  level,
  input  wire logic [7:0]                  bottom,
  input  wire logic                        pixel_value,
  output logic                             strobe,
  output logic [IDX_W-1:0]                 word_index,
  output logic [bglfb_pkg::WORD_WIDTH-1:0] word_value,
  output logic                             last
);

  bglfb_pkg::cmd_t  cmd;
  bglfb_pkg::stat_t stat;

  bglfb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  bglfb_dpath #(
    .WORD_COUNT (WORD_COUNT)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .opcode      (opcode),
    .column      (column),
    .level       (level),
    .bottom      (bottom),
    .pixel_value (pixel_value),
    .strobe      (strobe),
    .word_index  (word_index),
    .word_value  (word_value),
    .last        (last)
  );

  // a show run starts at word 0 and ends on the final word
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    $rose(strobe) |-> (word_index == '0))
    else $error("show run does not start at word 0");

  a_last_word: assert property (@(posedge clk) disable iff (rst)
    last |-> (strobe && (word_index == IDX_W'(WORD_COUNT - 1))))
    else $error("last flag off the final word");

  // words of a run come back to back
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> (strobe && (word_index == $past(word_index) + IDX_W'(1))))
    else $error("gap or skip in show run");

  // no results while idle apart from the tail of a run
  a_no_stray: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |-> busy)
    else $error("result outside a show run");

endmodule
`default_nettype wire

FILE: verif/tb.sv
`default_nettype none
module tb;

  // opcodes that the block takes and ignores
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;
  localparam int unsigned TOP_GROUP_ROWS = 4;
  localparam int RANDOM_CMDS = 206;
  localparam int TAIL_CYCLES = 24;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic [2:0] opcode;
    logic [3:0] column;
    logic [7:0] level;
    logic [7:0] bottom;
    logic       pixel_value;
    bit         drain;  // hold this command until all show words are back
  } led_cmd_t;

  typedef struct {
    logic [3:0]  index;
    logic [15:0] value;
    logic        last;
  } fb_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  opcode = '0;
  logic [3:0]  column = '0;
  logic [7:0]  level = '0;
  logic [7:0]  bottom = '0;
  logic        pixel_value = 1'b0;
  logic        strobe;
  logic [3:0]  word_index;
  logic [15:0] word_value;
  logic        last;

  logic [15:0] frame_shadow [16];
  led_cmd_t    cmd_queue [$];
  fb_word_t    show_words [$];
  led_cmd_t    in_flight;
  bit          took = 1'b0;
  int          burst_left = 1;
  int          gap_left = 0;
  int          mismatches = 0;

  bar_graph_led_frame_buffer DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .column(column), .level(level), .bottom(bottom),
    .pixel_value(pixel_value), .strobe(strobe), .word_index(word_index),
    .word_value(word_value), .last(last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // one LED of the shadow buffer: top four rows live in words 10..15
  function automatic void put_led(input logic [3:0] bar, input int unsigned row,
                                  input bit on);
    int unsigned w;
    int unsigned b;
    if (row < TOP_GROUP_ROWS) begin
      w = 32'(bglfb_pkg::HI_WORD_BASE) + 32'(bar % bglfb_pkg::BAR_SPLIT);
      b = (TOP_GROUP_ROWS - 1 - row) +
          ((bar >= bglfb_pkg::BAR_SPLIT) ? bglfb_pkg::NIBBLE_SHIFT : 0);
    end else begin
      w = 32'(bar);
      b = bglfb_pkg::ROW_COUNT - 1 - row;
    end
    frame_shadow[w][b] = on;
  endfunction

  // update the shadow buffer, queue the words a show returns
  function automatic void apply_command(input led_cmd_t c);
    fb_word_t    wd;
    int unsigned h;
    int unsigned top;
    int unsigned bot;
    int unsigned y;
    if (c.opcode == bglfb_pkg::OP_SHOW) begin
      for (int i = 0; i < 16; i++) begin
        wd.index = 4'(i);
        wd.value = frame_shadow[i];
        wd.last  = (i == 15);
        show_words.push_back(wd);
      end
      return;
    end
    if (c.opcode > bglfb_pkg::OP_SHOW || c.column >= bglfb_pkg::BAR_COUNT) return;
    case (c.opcode)
      bglfb_pkg::OP_HEIGHT: begin
        h = 32'(c.level);
        if (h > bglfb_pkg::HEIGHT_LIMIT) h = 0;
        if (h > bglfb_pkg::HEIGHT_MAX) h = 32'(bglfb_pkg::HEIGHT_MAX);
        for (int unsigned r = 0; r < bglfb_pkg::ROW_COUNT; r++)
          put_led(c.column, r, r >= bglfb_pkg::ROW_COUNT - h);
      end
      bglfb_pkg::OP_RANGE: begin
        top = (c.level > bglfb_pkg::MAX_ROW) ? 32'(bglfb_pkg::MAX_ROW) : 32'(c.level);
        bot = (c.bottom > bglfb_pkg::MAX_ROW) ? 32'(bglfb_pkg::MAX_ROW) : 32'(c.bottom);
        if (bot > top) bot = top;
        for (int unsigned r = 0; r < bglfb_pkg::ROW_COUNT; r++)
          put_led(c.column, r, r >= 32'(bglfb_pkg::MAX_ROW) - top &&
                               r <= 32'(bglfb_pkg::MAX_ROW) - bot);
      end
      bglfb_pkg::OP_DOT: begin
        y = (c.level > bglfb_pkg::MAX_ROW) ? 32'(bglfb_pkg::MAX_ROW) : 32'(c.level);
        put_led(c.column, 32'(bglfb_pkg::MAX_ROW) - y, 1'b1);
      end
      bglfb_pkg::OP_CLEAR: begin
        for (int unsigned r = 0; r < bglfb_pkg::ROW_COUNT; r++)
          put_led(c.column, r, 1'b0);
      end
      bglfb_pkg::OP_PIXEL: begin
        if (c.level < bglfb_pkg::ROW_COUNT)
          put_led(c.column, 32'(c.level), c.pixel_value);
      end
      default: ;
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, what);
  endtask

  task automatic add_cmd(input logic [2:0] op, input int col, input int lvl, input int bot,
                         input bit pix, input bit drain);
    led_cmd_t c;
    c.opcode      = op;
    c.column      = 4'(col);
    c.level       = 8'(lvl);
    c.bottom      = 8'(bot);
    c.pixel_value = pix;
    c.drain       = drain;
    cmd_queue.push_back(c);
  endtask

  // monitor: check a show word first, then predict the transaction taken here
  always @(posedge clk) begin
    fb_word_t want;
    took = 1'b0;
    if (!rst) begin
      if (strobe) begin
        if (show_words.size() == 0) begin
          flag_mismatch($sformatf("unexpected word idx=%0d value=%h last=%b",
                                  word_index, word_value, last));
        end else begin
          want = show_words.pop_front();
          if (word_index !== want.index || word_value !== want.value || last !== want.last)
            flag_mismatch($sformatf("word exp idx=%0d value=%h last=%b, got idx=%0d value=%h last=%b",
                                    want.index, want.value, want.last,
                                    word_index, word_value, last));
        end
      end
      if (start && !busy) begin
        took = 1'b1;
        apply_command(in_flight);
      end
    end
  end

  // driver: bursts of commands with random gaps
  always @(negedge clk) begin
    led_cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // hold the current transaction until it is taken
    end else if (gap_left > 0) begin
      gap_left <= gap_left - 1;
      start    <= 1'b0;
    end else if (cmd_queue.size() == 0 || (cmd_queue[0].drain && show_words.size() != 0)) begin
      start <= 1'b0;
    end else begin
      nxt = cmd_queue.pop_front();
      in_flight   <= nxt;
      opcode      <= nxt.opcode;
      column      <= nxt.column;
      level       <= nxt.level;
      bottom      <= nxt.bottom;
      pixel_value <= nxt.pixel_value;
      start       <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      end else begin
        burst_left <= burst_left - 1;
      end
    end
  end

  initial begin
    led_cmd_t c;
    int       r;
    for (int i = 0; i < 16; i++) frame_shadow[i] = '0;

    // directed: clamps, every opcode, bars out of range, spare opcodes
    add_cmd(bglfb_pkg::OP_SHOW,   0,   0,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_HEIGHT, 0,  20,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_HEIGHT, 1, 127,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_DOT,    2,   5,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_HEIGHT, 2, 128,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_HEIGHT, 9,  21,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_HEIGHT, 6,   7,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_RANGE,  3, 255, 255, 0, 0);
    add_cmd(bglfb_pkg::OP_RANGE,  7,  19,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_RANGE,  8,   4,  12, 0, 0);
    add_cmd(bglfb_pkg::OP_DOT,    9, 200,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_DOT,    5,   0,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_PIXEL,  4,   0,   0, 1, 0);
    add_cmd(bglfb_pkg::OP_PIXEL,  4,  19,   0, 1, 0);
    add_cmd(bglfb_pkg::OP_PIXEL,  4,  20,   0, 1, 0);
    add_cmd(bglfb_pkg::OP_PIXEL,  4, 255, 255, 1, 0);
    add_cmd(bglfb_pkg::OP_PIXEL,  0,   3,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_CLEAR,  1,   0,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_HEIGHT, 15, 20,   0, 0, 0);
    add_cmd(bglfb_pkg::OP_RANGE,  10, 19,   0, 0, 0);
    add_cmd(OP_SPARE6,            3, 255, 255, 1, 0);
    add_cmd(OP_SPARE7,            15, 255, 255, 1, 0);
    add_cmd(bglfb_pkg::OP_SHOW,   15, 255, 255, 1, 1);
    add_cmd(bglfb_pkg::OP_SHOW,   0,   0,   0, 0, 0);

    // random: mostly drawing on valid bars with meaningful rows
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      r = $urandom_range(0, 99);
      if (r < 16) c.opcode = bglfb_pkg::OP_SHOW;
      else if (r < 20) c.opcode = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
      else c.opcode = 3'($urandom_range(0, 4));
      c.column      = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, 9));
      c.level       = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 22));
      c.bottom      = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                  : 8'($urandom_range(0, 22));
      c.pixel_value = 1'($urandom_range(0, 1));
      c.drain       = ($urandom_range(0, 39) == 0);
      cmd_queue.push_back(c);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() != 0 || start) @(posedge clk);
    while (show_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire
